@@ hw/rtl/mec_pkg.sv @@
// ============================================================================
// mec_pkg - shared types and constants of the Mandelbrot escape counter
// Number format, widths, microcode control word and the microprogram ROM.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package mec_pkg;

    // Widths
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 28;
    localparam int FIX_W      = FRAC_BITS + 4;
    localparam int PROD_W     = 2 * FIX_W;
    localparam int SQ_W       = FIX_W - 1;
    localparam int GRID_W     = 13;
    localparam int LIMIT_W    = 16;
    localparam int TOTAL_W    = 40;
    localparam int DIV_N_W    = COORD_BITS + 3;
    localparam int DIV_D_W    = GRID_W + 1;
    localparam int DIV_STEPS  = FRAC_BITS + 2;
    localparam int RATIO_W    = FRAC_BITS + 3;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int UPC_W      = 4;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_LSB = 2;
    localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((LIMIT_W + TOTAL_W + 7) / 8) * 8;

    // Coordinate scales: x ratio is px*7/(2*size), y ratio is py*2/size
    localparam int X_SCALE = 7;
    localparam int Y_SCALE = 2;

    // Fixed point constants
    localparam logic [FIX_W-1:0]        ONE_FX    = FIX_W'(1) << FRAC_BITS;
    localparam logic [FIX_W-1:0]        X_OFFSET  = FIX_W'(5) << (FRAC_BITS - 1);
    localparam logic signed [FIX_W-1:0] MAG_CAP   = FIX_W'(5) << FRAC_BITS;
    localparam logic [FIX_W-1:0]        ESC_LIMIT = FIX_W'(4) << FRAC_BITS;
    localparam logic [RATIO_W-1:0]      RATIO_CAP = RATIO_W'(4) << FRAC_BITS;
    localparam logic [TOTAL_W-1:0]      TOTAL_MAX = TOTAL_W'(2147483647);

    // Configuration registers
    localparam logic [GRID_W-1:0]  GRID_SIZE_RST  = GRID_W'(800);
    localparam logic [LIMIT_W-1:0] ITER_LIMIT_RST = LIMIT_W'(1000);
    localparam logic REG_GRID_SIZE  = 1'b0;
    localparam logic REG_ITER_LIMIT = 1'b1;

    typedef logic [UPC_W-1:0] upc_t;

    // Microprogram addresses
    localparam upc_t UA_FETCH    = UPC_W'(0);
    localparam upc_t UA_LOAD_X   = UPC_W'(1);
    localparam upc_t UA_DIV_X    = UPC_W'(2);
    localparam upc_t UA_LOAD_Y   = UPC_W'(3);
    localparam upc_t UA_DIV_Y    = UPC_W'(4);
    localparam upc_t UA_START    = UPC_W'(5);
    localparam upc_t UA_MUL      = UPC_W'(6);
    localparam upc_t UA_UPDATE   = UPC_W'(7);
    localparam upc_t UA_WAIT_OUT = UPC_W'(8);
    localparam upc_t UA_FINISH   = UPC_W'(9);

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LATCH,
        DP_STORE_X0,
        DP_START,
        DP_MUL,
        DP_UPDATE,
        DP_FINISH
    } dp_op_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_LOAD_X,
        DIV_LOAD_Y,
        DIV_STEP
    } div_op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_CNT_NZ,
        COND_NO_ITER,
        COND_LOOP,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        dp_op_t  dp_op;
        div_op_t div_op;
        logic    cnt_load;
        cond_t   cond;
        upc_t    target;
    } ctrl_t;

    typedef struct packed {
        logic out_busy;
        logic no_iter;
        logic loop_go;
    } dp_flags_t;

    typedef struct packed {
        logic      in_valid;
        dp_flags_t dp;
    } status_t;

    function automatic ctrl_t ucode(input upc_t addr);
        ctrl_t w;
        begin
            w.dp_op    = DP_NOP;
            w.div_op   = DIV_IDLE;
            w.cnt_load = 1'b0;
            w.cond     = COND_NEVER;
            w.target   = UA_FETCH;
            unique case (addr)
                UA_FETCH:
                begin
                    w.dp_op  = DP_LATCH;
                    w.cond   = COND_NO_INPUT;
                    w.target = UA_FETCH;
                end
                UA_LOAD_X:
                begin
                    w.div_op   = DIV_LOAD_X;
                    w.cnt_load = 1'b1;
                end
                UA_DIV_X:
                begin
                    w.div_op = DIV_STEP;
                    w.cond   = COND_CNT_NZ;
                    w.target = UA_DIV_X;
                end
                UA_LOAD_Y:
                begin
                    w.dp_op    = DP_STORE_X0;
                    w.div_op   = DIV_LOAD_Y;
                    w.cnt_load = 1'b1;
                end
                UA_DIV_Y:
                begin
                    w.div_op = DIV_STEP;
                    w.cond   = COND_CNT_NZ;
                    w.target = UA_DIV_Y;
                end
                UA_START:
                begin
                    w.dp_op  = DP_START;
                    w.cond   = COND_NO_ITER;
                    w.target = UA_WAIT_OUT;
                end
                UA_MUL:
                begin
                    w.dp_op = DP_MUL;
                end
                UA_UPDATE:
                begin
                    w.dp_op  = DP_UPDATE;
                    w.cond   = COND_LOOP;
                    w.target = UA_MUL;
                end
                UA_WAIT_OUT:
                begin
                    w.cond   = COND_OUT_BUSY;
                    w.target = UA_WAIT_OUT;
                end
                UA_FINISH:
                begin
                    w.dp_op  = DP_FINISH;
                    w.cond   = COND_ALWAYS;
                    w.target = UA_FETCH;
                end
                default:
                begin
                    w.cond   = COND_ALWAYS;
                    w.target = UA_FETCH;
                end
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mec_sequencer.sv @@
// ============================================================================
// mec_sequencer - microprogram sequencer
// Step counter, control ROM, repeat counter and conditional jumps.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mec_sequencer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mec_pkg::status_t status,
    output mec_pkg::ctrl_t        ctrl
);

    mec_pkg::upc_t               upc_reg;
    mec_pkg::upc_t               upc_next;
    logic [mec_pkg::CNT_W-1:0]   cnt_reg;
    logic [mec_pkg::CNT_W-1:0]   cnt_next;
    logic                        cnt_nz;
    logic                        jump;

    assign ctrl   = mec_pkg::ucode(upc_reg);
    assign cnt_nz = (cnt_reg != '0);

    always_comb
    begin
        case (ctrl.cond)
            mec_pkg::COND_NEVER:    jump = 1'b0;
            mec_pkg::COND_ALWAYS:   jump = 1'b1;
            mec_pkg::COND_NO_INPUT: jump = !status.in_valid;
            mec_pkg::COND_CNT_NZ:   jump = cnt_nz;
            mec_pkg::COND_NO_ITER:  jump = status.dp.no_iter;
            mec_pkg::COND_LOOP:     jump = status.dp.loop_go;
            mec_pkg::COND_OUT_BUSY: jump = status.dp.out_busy;
            default:                jump = 1'b0;
        endcase
    end

    always_comb
    begin
        upc_next = jump ? ctrl.target : upc_reg + mec_pkg::UPC_W'(1);
        cnt_next = cnt_reg;
        if (ctrl.cnt_load)
        begin
            cnt_next = mec_pkg::CNT_W'(mec_pkg::DIV_STEPS - 1);
        end
        else if ((ctrl.cond == mec_pkg::COND_CNT_NZ) && cnt_nz)
        begin
            cnt_next = cnt_reg - mec_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= mec_pkg::UA_FETCH;
            cnt_reg <= '0;
        end
        else
        begin
            upc_reg <= upc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mec_divider.sv @@
// ============================================================================
// mec_divider - coordinate ratio divider
// Restoring divider, one quotient bit per step, capped at 4.0.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mec_divider (
    input  wire logic                            clk,
    input  wire mec_pkg::div_op_t                op,
    input  wire logic [mec_pkg::COORD_BITS-1:0]  px,
    input  wire logic [mec_pkg::COORD_BITS-1:0]  py,
    input  wire logic [mec_pkg::GRID_W-1:0]      grid_size,
    output logic [mec_pkg::RATIO_W-1:0]          ratio
);

    logic [mec_pkg::GRID_W-1:0]    size;
    logic [mec_pkg::DIV_N_W-1:0]   n_load;
    logic [mec_pkg::DIV_D_W-1:0]   d_load;
    logic [mec_pkg::DIV_D_W:0]     trial;
    logic                          fits;

    logic [mec_pkg::DIV_D_W-1:0]   r_reg;
    logic [mec_pkg::DIV_D_W-1:0]   r_next;
    logic [mec_pkg::DIV_D_W-1:0]   d_reg;
    logic [mec_pkg::DIV_D_W-1:0]   d_next;
    logic [1:0]                    nlo_reg;
    logic [1:0]                    nlo_next;
    logic [mec_pkg::DIV_STEPS-1:0] q_reg;
    logic [mec_pkg::DIV_STEPS-1:0] q_next;
    logic                          cap_reg;
    logic                          cap_next;

    always_comb
    begin
        size = (grid_size == '0) ? mec_pkg::GRID_W'(1) : grid_size;
        if (op == mec_pkg::DIV_LOAD_X)
        begin
            n_load = mec_pkg::DIV_N_W'(px) * mec_pkg::DIV_N_W'(mec_pkg::X_SCALE);
            d_load = {size, 1'b0};
        end
        else
        begin
            n_load = mec_pkg::DIV_N_W'(py) * mec_pkg::DIV_N_W'(mec_pkg::Y_SCALE);
            d_load = mec_pkg::DIV_D_W'(size);
        end
        trial = {r_reg, nlo_reg[1]};
        fits  = (trial >= (mec_pkg::DIV_D_W + 1)'(d_reg));
    end

    always_comb
    begin
        r_next   = r_reg;
        d_next   = d_reg;
        nlo_next = nlo_reg;
        q_next   = q_reg;
        cap_next = cap_reg;
        unique case (op) inside
            mec_pkg::DIV_LOAD_X, mec_pkg::DIV_LOAD_Y:
            begin
                r_next   = mec_pkg::DIV_D_W'(n_load >> 2);
                d_next   = d_load;
                nlo_next = n_load[1:0];
                q_next   = '0;
                cap_next = (32'(n_load) >= (32'(d_load) << 2));
            end
            mec_pkg::DIV_STEP:
            begin
                r_next   = fits ? mec_pkg::DIV_D_W'(trial - (mec_pkg::DIV_D_W + 1)'(d_reg))
                                : mec_pkg::DIV_D_W'(trial);
                nlo_next = {nlo_reg[0], 1'b0};
                q_next   = {q_reg[mec_pkg::DIV_STEPS-2:0], fits};
            end
            default:
            begin
                r_next = r_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        d_reg   <= d_next;
        nlo_reg <= nlo_next;
        q_reg   <= q_next;
        cap_reg <= cap_next;
    end

    assign ratio = cap_reg ? mec_pkg::RATIO_CAP : mec_pkg::RATIO_W'(q_reg);

endmodule

`default_nettype wire

@@ hw/rtl/mec_datapath.sv @@
// ============================================================================
// mec_datapath - escape iteration datapath
// Point registers, square and cross products, update, total and output item.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mec_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mec_pkg::dp_op_t                 op,
    input  wire logic                            in_accept,
    input  wire logic [mec_pkg::COORD_BITS-1:0]  pixel_x,
    input  wire logic [mec_pkg::COORD_BITS-1:0]  pixel_y,
    input  wire logic                            clear_total,
    input  wire logic [mec_pkg::LIMIT_W-1:0]     iteration_limit,
    input  wire logic [mec_pkg::RATIO_W-1:0]     ratio,
    input  wire logic                            out_ready,
    output logic [mec_pkg::COORD_BITS-1:0]       px,
    output logic [mec_pkg::COORD_BITS-1:0]       py,
    output mec_pkg::dp_flags_t                   flags,
    output logic                                 out_valid,
    output logic [mec_pkg::LIMIT_W-1:0]          escape_count,
    output logic [mec_pkg::TOTAL_W-1:0]          running_total
);

    localparam int FL_W = mec_pkg::PROD_W - mec_pkg::FRAC_BITS;
    localparam int SUM_W = mec_pkg::FIX_W + 2;
    localparam logic signed [FL_W-1:0] CAP_L = FL_W'(mec_pkg::MAG_CAP);

    logic [mec_pkg::COORD_BITS-1:0]     px_reg, px_next;
    logic [mec_pkg::COORD_BITS-1:0]     py_reg, py_next;
    logic                               clr_reg, clr_next;
    logic signed [mec_pkg::FIX_W-1:0]   x0_reg, x0_next;
    logic signed [mec_pkg::FIX_W-1:0]   y0_reg, y0_next;
    logic signed [mec_pkg::FIX_W-1:0]   x_reg, x_next;
    logic signed [mec_pkg::FIX_W-1:0]   y_reg, y_next;
    logic [mec_pkg::SQ_W-1:0]           xx_reg, xx_next;
    logic [mec_pkg::SQ_W-1:0]           yy_reg, yy_next;
    logic signed [mec_pkg::FIX_W-1:0]   xy_reg, xy_next;
    logic                               xyc_reg, xyc_next;
    logic [mec_pkg::LIMIT_W-1:0]        iter_reg, iter_next;
    logic [mec_pkg::TOTAL_W-1:0]        total_reg, total_next;
    logic                               out_valid_reg, out_valid_next;
    logic [mec_pkg::LIMIT_W-1:0]        out_count_reg, out_count_next;
    logic [mec_pkg::TOTAL_W-1:0]        out_total_reg, out_total_next;

    logic signed [mec_pkg::PROD_W-1:0]  p_xx, p_yy, p_xy;
    logic signed [FL_W-1:0]             fl_xx, fl_yy, fl_xy;
    logic [mec_pkg::SQ_W-1:0]           sq_xx, sq_yy;
    logic signed [mec_pkg::FIX_W-1:0]   cr_xy;
    logic                               cr_c;
    logic [mec_pkg::FIX_W-1:0]          sq_sum;
    logic                               esc;
    logic signed [SUM_W-1:0]            x_sum, y_sum;
    logic [mec_pkg::TOTAL_W-1:0]        total_base, total_sum, total_sat;

    // Products, floor by the fraction width, magnitude held at 5.0
    always_comb
    begin
        p_xx  = x_reg * x_reg;
        p_yy  = y_reg * y_reg;
        p_xy  = x_reg * y_reg;
        fl_xx = p_xx[mec_pkg::PROD_W-1:mec_pkg::FRAC_BITS];
        fl_yy = p_yy[mec_pkg::PROD_W-1:mec_pkg::FRAC_BITS];
        fl_xy = p_xy[mec_pkg::PROD_W-1:mec_pkg::FRAC_BITS];
        sq_xx = (fl_xx > CAP_L) ? mec_pkg::SQ_W'(mec_pkg::MAG_CAP) : fl_xx[mec_pkg::SQ_W-1:0];
        sq_yy = (fl_yy > CAP_L) ? mec_pkg::SQ_W'(mec_pkg::MAG_CAP) : fl_yy[mec_pkg::SQ_W-1:0];
        if (fl_xy > CAP_L)
        begin
            cr_xy = mec_pkg::MAG_CAP;
            cr_c  = 1'b0;
        end
        else if (fl_xy < -CAP_L)
        begin
            cr_xy = -mec_pkg::MAG_CAP;
            cr_c  = 1'b0;
        end
        else
        begin
            // round a negative product toward zero
            cr_xy = mec_pkg::FIX_W'(fl_xy);
            cr_c  = p_xy[mec_pkg::PROD_W-1] && (p_xy[mec_pkg::FRAC_BITS-1:0] != '0);
        end
    end

    always_comb
    begin
        sq_sum = mec_pkg::FIX_W'(xx_reg) + mec_pkg::FIX_W'(yy_reg);
        esc    = (sq_sum > mec_pkg::ESC_LIMIT);
        x_sum  = signed'(SUM_W'(xx_reg)) - signed'(SUM_W'(yy_reg)) + SUM_W'(x0_reg);
        y_sum  = (SUM_W'(xy_reg) <<< 1) + SUM_W'(y0_reg) + signed'(SUM_W'({xyc_reg, 1'b0}));
        total_base = clr_reg ? '0 : total_reg;
        total_sum  = total_base + mec_pkg::TOTAL_W'(iter_reg);
        total_sat  = (total_sum > mec_pkg::TOTAL_MAX) ? mec_pkg::TOTAL_MAX : total_sum;
    end

    always_comb
    begin
        px_next        = px_reg;
        py_next        = py_reg;
        clr_next       = clr_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        xx_next        = xx_reg;
        yy_next        = yy_reg;
        xy_next        = xy_reg;
        xyc_next       = xyc_reg;
        iter_next      = iter_reg;
        total_next     = total_reg;
        out_count_next = out_count_reg;
        out_total_next = out_total_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (op)
            mec_pkg::DP_LATCH:
            begin
                if (in_accept)
                begin
                    px_next  = pixel_x;
                    py_next  = pixel_y;
                    clr_next = clear_total;
                end
            end
            mec_pkg::DP_STORE_X0:
            begin
                x0_next = mec_pkg::FIX_W'(ratio) - mec_pkg::X_OFFSET;
            end
            mec_pkg::DP_START:
            begin
                y0_next   = mec_pkg::FIX_W'(ratio) - mec_pkg::ONE_FX;
                x_next    = '0;
                y_next    = '0;
                iter_next = '0;
            end
            mec_pkg::DP_MUL:
            begin
                xx_next  = sq_xx;
                yy_next  = sq_yy;
                xy_next  = cr_xy;
                xyc_next = cr_c;
            end
            mec_pkg::DP_UPDATE:
            begin
                if (!esc)
                begin
                    x_next    = mec_pkg::FIX_W'(x_sum);
                    y_next    = mec_pkg::FIX_W'(y_sum);
                    iter_next = iter_reg + mec_pkg::LIMIT_W'(1);
                end
            end
            mec_pkg::DP_FINISH:
            begin
                total_next     = total_sat;
                out_count_next = iter_reg;
                out_total_next = total_sat;
                out_valid_next = 1'b1;
            end
            default:
            begin
                iter_next = iter_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        px_reg        <= px_next;
        py_reg        <= py_next;
        clr_reg       <= clr_next;
        x0_reg        <= x0_next;
        y0_reg        <= y0_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        xx_reg        <= xx_next;
        yy_reg        <= yy_next;
        xy_reg        <= xy_next;
        xyc_reg       <= xyc_next;
        iter_reg      <= iter_next;
        out_count_reg <= out_count_next;
        out_total_reg <= out_total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign px             = px_reg;
    assign py             = py_reg;
    assign flags.out_busy = out_valid_reg && !out_ready;
    assign flags.no_iter  = (iteration_limit == '0);
    assign flags.loop_go  = !esc && (((mec_pkg::LIMIT_W + 1)'(iter_reg) + 1'b1)
                                     < (mec_pkg::LIMIT_W + 1)'(iteration_limit));
    assign out_valid      = out_valid_reg;
    assign escape_count   = out_count_reg;
    assign running_total  = out_total_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mandelbrot_escape_counter.sv @@
// ============================================================================
// mandelbrot_escape_counter - Mandelbrot escape-time counter
// Maps a pixel onto the complex plane, counts escape iterations, keeps a
// saturating running total of the counts that clear_total can reset.
// ============================================================================
// One pixel item in, one result item out. After a pixel item is taken, the
// microprogram works out each coordinate ratio (a load and 30 quotient bits
// from the restoring divider), first x, then y, and then starts the loop.
// Each iteration takes two microcode steps, one for the three products and
// one for the compare and update; the loop ends on escape or at the iteration
// limit and is skipped for a limit of zero. The output check and the finish
// follow. The next item can be taken at the edge after m_tvalid rises, so a
// new pixel item is not taken before the last one's result is out. The next
// item is taken while a finished result still waits on the output; its own
// result holds in the output check until the earlier result is taken.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_counter (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // APB configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mec_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [mec_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mec_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                    pready,
    // pixel items
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [mec_pkg::IN_DATA_W-1:0]      s_tdata,  // pixel_x, pixel_y
    input  wire logic                               s_tuser,  // clear_total
    // result items
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [mec_pkg::OUT_DATA_W-1:0]          m_tdata   // escape_count, running_total
);

    logic [mec_pkg::GRID_W-1:0]      grid_size_reg, grid_size_next;
    logic [mec_pkg::LIMIT_W-1:0]     iteration_limit_reg, iteration_limit_next;
    logic                            cfg_write;
    logic                            cfg_idx;

    mec_pkg::ctrl_t                  ctrl;
    mec_pkg::status_t                status;
    mec_pkg::dp_flags_t              flags;
    logic                            in_accept;
    logic [mec_pkg::COORD_BITS-1:0]  px;
    logic [mec_pkg::COORD_BITS-1:0]  py;
    logic [mec_pkg::RATIO_W-1:0]     ratio;
    logic [mec_pkg::LIMIT_W-1:0]     escape_count;
    logic [mec_pkg::TOTAL_W-1:0]     running_total;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[mec_pkg::REG_IDX_LSB];

    always_comb
    begin
        grid_size_next       = grid_size_reg;
        iteration_limit_next = iteration_limit_reg;
        if (cfg_write)
        begin
            if (cfg_idx == mec_pkg::REG_GRID_SIZE)
            begin
                grid_size_next = pwdata[mec_pkg::GRID_W-1:0];
            end
            else
            begin
                iteration_limit_next = pwdata[mec_pkg::LIMIT_W-1:0];
            end
        end
        if (cfg_idx == mec_pkg::REG_GRID_SIZE)
        begin
            prdata = mec_pkg::APB_DATA_W'(grid_size_reg);
        end
        else
        begin
            prdata = mec_pkg::APB_DATA_W'(iteration_limit_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg       <= mec_pkg::GRID_SIZE_RST;
            iteration_limit_reg <= mec_pkg::ITER_LIMIT_RST;
        end
        else
        begin
            grid_size_reg       <= grid_size_next;
            iteration_limit_reg <= iteration_limit_next;
        end
    end

    // Handshake
    assign s_tready        = (ctrl.dp_op == mec_pkg::DP_LATCH);
    assign in_accept       = s_tvalid && s_tready;
    assign status.in_valid = s_tvalid;
    assign status.dp       = flags;
    assign m_tdata         = mec_pkg::OUT_DATA_W'({running_total, escape_count});

    mec_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    mec_divider u_div (
        .clk       (clk),
        .op        (ctrl.div_op),
        .px        (px),
        .py        (py),
        .grid_size (grid_size_reg),
        .ratio     (ratio)
    );

    mec_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (ctrl.dp_op),
        .in_accept       (in_accept),
        .pixel_x         (s_tdata[mec_pkg::COORD_BITS-1:0]),
        .pixel_y         (s_tdata[2*mec_pkg::COORD_BITS-1:mec_pkg::COORD_BITS]),
        .clear_total     (s_tuser),
        .iteration_limit (iteration_limit_reg),
        .ratio           (ratio),
        .out_ready       (m_tready),
        .px              (px),
        .py              (py),
        .flags           (flags),
        .out_valid       (m_tvalid),
        .escape_count    (escape_count),
        .running_total   (running_total)
    );

`ifndef SYNTHESIS
    a_total_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (running_total <= mec_pkg::TOTAL_MAX))
        else $error("running total above saturation value");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (escape_count <= iteration_limit_reg))
        else $error("escape count above iteration limit");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_tready)
        else $error("second item taken while one is in work");
`endif

endmodule

`default_nettype wire

@@ sim/mandelbrot_escape_counter_tb.sv @@
// ============================================================================
// mandelbrot_escape_counter_tb - self-checking bench of the escape counter
// Drives pixel items and register writes, predicts each escape count and
// running total in fixed point, and checks every result item in order.
// ============================================================================
`timescale 1ns / 1ps

module mandelbrot_escape_counter_tb;

    localparam int              FRAC         = mec_pkg::FRAC_BITS;
    localparam longint unsigned FX_ONE       = 64'd1 << FRAC;
    localparam longint unsigned SQUARE_CAP   = 5 * FX_ONE;
    localparam longint unsigned ESCAPE_BOUND = 4 * FX_ONE;
    localparam longint unsigned RATIO_TOP    = 4 * FX_ONE;
    localparam longint unsigned X_SHIFT      = 5 * (FX_ONE >> 1);
    localparam longint unsigned SUM_CEIL     = 64'd2147483647;
    localparam int              CYCLE_LIMIT  = 3000000;
    localparam int              HOLD_CYCLES  = 2500;
    localparam int              END_QUIET    = 300;

    typedef struct {
        logic [mec_pkg::LIMIT_W-1:0] steps;
        logic [mec_pkg::TOTAL_W-1:0] total;
    } escape_result_t;

    class escape_ledger;
        logic [mec_pkg::GRID_W-1:0]  grid_size;
        logic [mec_pkg::LIMIT_W-1:0] iter_limit;
        longint unsigned             count_sum;
        escape_result_t              awaited[$];
        int unsigned                 errors;
        int unsigned                 results_seen;

        function new();
            grid_size    = mec_pkg::GRID_SIZE_RST;
            iter_limit   = mec_pkg::ITER_LIMIT_RST;
            count_sum    = 0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function longint unsigned fx_mag(longint v);
            return (v < 0) ? unsigned'(-v) : unsigned'(v);
        endfunction

        // product of magnitudes, truncated, held at 5.0
        function longint unsigned fx_mul(longint unsigned a, longint unsigned b);
            logic [127:0] prod;
            prod = ({64'd0, a} * {64'd0, b}) >> FRAC;
            return (prod > SQUARE_CAP) ? SQUARE_CAP : prod[63:0];
        endfunction

        function longint fx_smul(longint a, longint b);
            longint r;
            r = longint'(fx_mul(fx_mag(a), fx_mag(b)));
            return ((a < 0) != (b < 0)) ? -r : r;
        endfunction

        function longint unsigned fx_ratio(longint unsigned num, longint unsigned den);
            if (num / den >= 4)
            begin
                return RATIO_TOP;
            end
            return (num << FRAC) / den;
        endfunction

        function int unsigned count_escape(logic [11:0] px, logic [11:0] py);
            longint unsigned side;
            longint unsigned xx;
            longint unsigned yy;
            longint          x0;
            longint          y0;
            longint          x;
            longint          y;
            longint          x_next;
            int unsigned     n;
            side = (grid_size == 0) ? 64'd1 : 64'(grid_size);
            x0 = longint'(fx_ratio(64'(px) * 7, side * 2)) - longint'(X_SHIFT);
            y0 = longint'(fx_ratio(64'(py) * 2, side)) - longint'(FX_ONE);
            x = 0;
            y = 0;
            n = 0;
            while (n < iter_limit)
            begin
                xx = fx_mul(fx_mag(x), fx_mag(x));
                yy = fx_mul(fx_mag(y), fx_mag(y));
                if (xx + yy > ESCAPE_BOUND)
                begin
                    break;
                end
                x_next = longint'(xx) - longint'(yy) + x0;
                y = 2 * fx_smul(x, y) + y0;
                x = x_next;
                n++;
            end
            return n;
        endfunction

        function void note_pixel(logic [11:0] px, logic [11:0] py, logic clr);
            escape_result_t r;
            int unsigned    n;
            n = count_escape(px, py);
            if (clr)
            begin
                count_sum = 0;
            end
            count_sum = count_sum + n;
            if (count_sum > SUM_CEIL)
            begin
                count_sum = SUM_CEIL;
            end
            r.steps = n[mec_pkg::LIMIT_W-1:0];
            r.total = count_sum[mec_pkg::TOTAL_W-1:0];
            awaited.push_back(r);
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] MISMATCH %s", $time, what);
        endtask

        task check_result(logic [mec_pkg::LIMIT_W-1:0] steps,
                          logic [mec_pkg::TOTAL_W-1:0] total);
            escape_result_t exp;
            results_seen++;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result count=%0d total=%0d", steps, total));
                return;
            end
            exp = awaited.pop_front();
            if (steps !== exp.steps)
            begin
                report($sformatf("escape_count %0d, want %0d", steps, exp.steps));
            end
            if (total !== exp.total)
            begin
                report($sformatf("running_total %0d, want %0d", total, exp.total));
            end
        endtask
    endclass

    logic                                clk      = 1'b0;
    logic                                rst_n    = 1'b0;
    logic                                psel     = 1'b0;
    logic                                penable  = 1'b0;
    logic                                pwrite   = 1'b0;
    logic [mec_pkg::APB_ADDR_W-1:0]      paddr    = '0;
    logic [mec_pkg::APB_DATA_W-1:0]      pwdata   = '0;
    logic [mec_pkg::APB_DATA_W-1:0]      prdata;
    logic                                pready;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [mec_pkg::IN_DATA_W-1:0]       s_tdata  = '0;  // pixel_x, pixel_y
    logic                                s_tuser  = 1'b0; // clear_total
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [mec_pkg::OUT_DATA_W-1:0]      m_tdata;        // escape_count, running_total

    escape_ledger ledger;
    bit           s_idle_on = 1'b0;
    bit           m_idle_on = 1'b0;
    bit           hold_req  = 1'b0;
    int unsigned  pixels_sent = 0;
    int unsigned  settings_cnt = 0;
    int unsigned  hold_cnt = 0;
    int unsigned  cycle_cnt = 0;

    mandelbrot_escape_counter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", cycle_cnt);
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                ledger.note_pixel(s_tdata[11:0], s_tdata[23:12], s_tuser);
            end
            if (m_tvalid && m_tready)
            begin
                ledger.check_result(m_tdata[mec_pkg::LIMIT_W-1:0],
                                    m_tdata[mec_pkg::LIMIT_W +: mec_pkg::TOTAL_W]);
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = m_idle_on ? $urandom_range(0, 7) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic write_reg(input logic idx, input logic [mec_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mec_pkg::APB_ADDR_W'(idx) << mec_pkg::REG_IDX_LSB;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == mec_pkg::REG_GRID_SIZE)
        begin
            ledger.grid_size = value[mec_pkg::GRID_W-1:0];
        end
        else
        begin
            ledger.iter_limit = value[mec_pkg::LIMIT_W-1:0];
        end
        @(posedge clk);
    endtask

    task automatic set_view(input logic [12:0] grid, input logic [15:0] limit);
        write_reg(mec_pkg::REG_GRID_SIZE, 32'(grid));
        write_reg(mec_pkg::REG_ITER_LIMIT, 32'(limit));
        settings_cnt++;
    endtask

    task automatic send_pixel(input logic [11:0] px, input logic [11:0] py, input logic clr);
        int gap;
        gap = s_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        s_tuser  <= clr;
        do @(posedge clk); while (!s_tready);
        pixels_sent++;
    endtask

    // hold input low until every result of the sent pixels is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (ledger.results_seen < pixels_sent)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_phase(input logic [12:0] grid, input logic [15:0] limit, input int n,
                             input bit s_idle, input bit m_idle, input bit hold);
        int          span;
        logic [11:0] px;
        logic [11:0] py;
        set_view(grid, limit);
        s_idle_on = s_idle;
        m_idle_on = m_idle;
        hold_req  = hold;
        span = (grid == 0) ? 1 : ((grid > 4096) ? 4096 : int'(grid));
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                px = 12'($urandom_range(0, span - 1));
                py = 12'($urandom_range(0, span - 1));
            end
            else
            begin
                px = 12'($urandom_range(0, 4095));
                py = 12'($urandom_range(0, 4095));
            end
            send_pixel(px, py, $urandom_range(0, 15) == 0);
        end
        drain_results();
    endtask

    initial
    begin
        ledger = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: fast escape, interior point, outside grid, grid edge
        send_pixel(12'd0, 12'd0, 1'b1);
        send_pixel(12'd457, 12'd400, 1'b0);
        send_pixel(12'd4095, 12'd4095, 1'b0);
        send_pixel(12'd800, 12'd800, 1'b0);
        drain_results();

        // zero limit and zero grid
        set_view(13'd0, 16'd0);
        send_pixel(12'd0, 12'd0, 1'b0);
        send_pixel(12'd4095, 12'd4095, 1'b1);
        send_pixel(12'd1, 12'd0, 1'b0);
        drain_results();

        set_view(13'd0, 16'd16);
        send_pixel(12'd0, 12'd0, 1'b0);
        send_pixel(12'd1, 12'd1, 1'b0);
        send_pixel(12'd4095, 12'd0, 1'b0);
        send_pixel(12'd0, 12'd4095, 1'b1);
        drain_results();

        // widest grid, deepest limit
        set_view(13'd8191, 16'd65535);
        send_pixel(12'd4095, 12'd4095, 1'b1);
        send_pixel(12'd0, 12'd0, 1'b0);
        send_pixel(12'd4095, 12'd0, 1'b0);
        drain_results();

        set_view(13'd4096, 16'd1);
        send_pixel(12'd4095, 12'd4095, 1'b0);
        send_pixel(12'd0, 12'd0, 1'b1);
        send_pixel(12'd2048, 12'd2048, 1'b0);
        drain_results();

        run_phase(13'd4096, 16'd1, 40, 1'b1, 1'b1, 1'b0);
        run_phase(13'd1, 16'd255, 40, 1'b0, 1'b1, 1'b0);
        run_phase(13'd64, 16'd100, 80, 1'b0, 1'b0, 1'b1);
        run_phase(13'($urandom_range(1, 4096)), 16'($urandom_range(2, 300)), 80,
                  1'b0, 1'b0, 1'b0);
        run_phase(mec_pkg::GRID_SIZE_RST, 16'd200, 80, 1'b1, 1'b1, 1'b0);
        run_phase(13'($urandom_range(1, 8191)), 16'($urandom_range(1, 128)), 80,
                  1'b1, 1'b0, 1'b0);
        run_phase(13'd8191, 16'd300, 80, 1'b0, 1'b1, 1'b0);
        run_phase(13'd16, 16'd64, 90, 1'b1, 1'b1, 1'b1);

        repeat (END_QUIET) @(posedge clk);
        if (ledger.awaited.size() != 0)
        begin
            ledger.report($sformatf("%0d results never arrived", ledger.awaited.size()));
        end
        $display("covered %0d pixels over %0d grid/limit settings, %0d results checked",
                 pixels_sent, settings_cnt, ledger.results_seen);
        $display("grid 0..8191, limit 0..65535, %0d output hold-offs, %0d mismatches",
                 hold_cnt, ledger.errors);
        if (ledger.errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
